// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [LEN_W-1:0]  position;
		logic signed [31:0] value;
	} sle_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [IDX_W-1:0]   found_index;
		logic signed [31:0] read_value;
		logic [LEN_W-1:0]   removed_count;
		logic [LEN_W-1:0]   list_length;
	} sle_res_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} sle_cmd_t;

	typedef struct packed {
		logic ins_err;
		logic issue_done;
		logic s1_valid;
	} sle_stat_t;

endpackage

// ===== rtl/core/sle_ctrl.sv =====
module sle_ctrl
	import sle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sle_stat_t stat,
	output sle_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.ins_err ? S_FINISH : S_WALK;
			end
			S_WALK: begin
				cmd.issue = !stat.issue_done;
				if (stat.issue_done && !stat.s1_valid) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== rtl/core/sle_datapath.sv =====
module sle_datapath
	import sle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sle_req_t  request,
	input  sle_cmd_t  cmd,
	output sle_stat_t stat,
	output sle_res_t  result
);

	logic signed [31:0] mem [CAPACITY];

	logic [1:0]         op_q;
	logic [LEN_W-1:0]   pos_q;
	logic signed [31:0] val_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   wr_q;
	logic [LEN_W-1:0]   removed_q;
	logic               hit_q;
	logic [IDX_W-1:0]   found_q;
	logic signed [31:0] rdval_q;
	logic               rd_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic signed [31:0] rd_data_s1;
	sle_res_t           res_q;

	logic               full;
	logic               pos_bad;
	logic               match;
	logic [IDX_W-1:0]   rd_addr;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic signed [31:0] wdata;
	logic [LEN_W-1:0]   new_len;
	sle_res_t           res_d;

	assign full    = (len_q >= LEN_W'(CAPACITY));
	assign pos_bad = (pos_q > len_q);
	assign match   = (rd_data_s1 == val_q);

	always_comb begin
		stat.ins_err  = (op_q == OP_INSERT) && (full || pos_bad);
		stat.s1_valid = rd_s1;
		unique case (op_q)
			OP_INSERT: stat.issue_done = (cnt_q <= pos_q);
			OP_DELETE: stat.issue_done = (cnt_q >= len_q);
			OP_FIND:   stat.issue_done = (cnt_q >= len_q) || hit_q;
			OP_READ:   stat.issue_done = (cnt_q != '0) || (pos_q >= len_q);
			default:   stat.issue_done = 1'b1;
		endcase
	end

	// Insert walks downward, reading the entry below the slot it fills.
	always_comb begin
		unique case (op_q)
			OP_INSERT: rd_addr = IDX_W'(cnt_q - LEN_W'(1));
			OP_READ:   rd_addr = pos_q[IDX_W-1:0];
			default:   rd_addr = cnt_q[IDX_W-1:0];
		endcase
	end

	// One write port: the read-back stage and the final insert never overlap.
	always_comb begin
		we    = 1'b0;
		waddr = rd_idx_s1;
		wdata = rd_data_s1;
		if (cmd.finish) begin
			we    = (op_q == OP_INSERT) && !stat.ins_err;
			waddr = pos_q[IDX_W-1:0];
			wdata = val_q;
		end else if (rd_s1) begin
			if (op_q == OP_INSERT) begin
				we    = 1'b1;
				waddr = IDX_W'(rd_idx_s1 + IDX_W'(1));
			end else if (op_q == OP_DELETE && !match) begin
				we    = 1'b1;
				waddr = wr_q[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_comb begin
		new_len = len_q;
		if (op_q == OP_INSERT && !stat.ins_err) begin
			new_len = LEN_W'(len_q + LEN_W'(1));
		end else if (op_q == OP_DELETE) begin
			new_len = wr_q;
		end
	end

	always_comb begin
		res_d               = '0;
		res_d.list_length   = new_len;
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else if (pos_bad) begin
					res_d.status = ST_RANGE;
				end else begin
					res_d.status = ST_OK;
				end
			end
			OP_DELETE: begin
				res_d.removed_count = removed_q;
				res_d.status        = (removed_q == '0) ? ST_NOTFOUND : ST_OK;
			end
			OP_FIND: begin
				res_d.found_index = hit_q ? found_q : '0;
				res_d.status      = hit_q ? ST_OK : ST_NOTFOUND;
			end
			OP_READ: begin
				res_d.read_value = rdval_q;
				res_d.status     = (pos_q < len_q) ? ST_OK : ST_RANGE;
			end
			default: begin
				res_d.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.issue;
			if (cmd.finish) begin
				len_q <= new_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= request.operation;
			pos_q     <= request.position;
			val_q     <= request.value;
			cnt_q     <= (request.operation == OP_INSERT) ? len_q : '0;
			wr_q      <= '0;
			removed_q <= '0;
			hit_q     <= 1'b0;
			found_q   <= '0;
			rdval_q   <= '0;
		end else begin
			if (cmd.issue) begin
				if (op_q == OP_INSERT) begin
					cnt_q <= LEN_W'(cnt_q - LEN_W'(1));
				end else begin
					cnt_q <= LEN_W'(cnt_q + LEN_W'(1));
				end
			end
			if (rd_s1) begin
				unique case (op_q)
					OP_DELETE: begin
						if (match) begin
							removed_q <= LEN_W'(removed_q + LEN_W'(1));
						end else begin
							wr_q <= LEN_W'(wr_q + LEN_W'(1));
						end
					end
					OP_FIND: begin
						if (match && !hit_q) begin
							hit_q   <= 1'b1;
							found_q <= rd_idx_s1;
						end
					end
					OP_READ: begin
						rdval_q <= rd_data_s1;
					end
					default: begin
					end
				endcase
			end
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/core/sequential_list_engine.sv =====
// A word accepted in idle passes the check state, then, unless it is a rejected
// insert, the walk, one entry per cycle through the list memory (single read port),
// then the finish and done states. busy drops after done, so a new word is taken only
// once the last is through; done pulses for one cycle and the receiver cannot stall it.
// Reset clears the length and the controller; list contents are unknown until written.
module sequential_list_engine
	import sle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sle_req_t request,
	output logic     busy,
	output logic     done,
	output sle_res_t result
);

	sle_cmd_t  cmd;
	sle_stat_t stat;

	sle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sle_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import sle_pkg::*;

	class list_shadow;
		logic signed [31:0] entries [CAPACITY];
		int unsigned length;
		sle_res_t pending_results[$];
		int unsigned errors;
		int unsigned mismatches;

		function new();
			length = 0;
			errors = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted word to the shadow list and queues the result it must give.
		function void note_request(sle_req_t req);
			sle_res_t res;
			int unsigned pos;
			int unsigned kept;
			int unsigned k;
			bit hit;
			res = '0;
			pos = req.position;
			hit = 0;
			case (req.operation)
				OP_INSERT: begin
					if (length >= CAPACITY) begin
						res.status = ST_FULL;
					end else if (pos > length) begin
						res.status = ST_RANGE;
					end else begin
						for (k = length; k > pos; k--)
							entries[k] = entries[k - 1];
						entries[pos] = req.value;
						length++;
					end
				end
				OP_DELETE: begin
					kept = 0;
					for (k = 0; k < length; k++) begin
						if (entries[k] === req.value) begin
							res.removed_count++;
						end else begin
							entries[kept] = entries[k];
							kept++;
						end
					end
					length = kept;
					if (res.removed_count == 0)
						res.status = ST_NOTFOUND;
				end
				OP_FIND: begin
					for (k = 0; k < length && !hit; k++) begin
						if (entries[k] === req.value) begin
							res.found_index = k[IDX_W-1:0];
							hit = 1;
						end
					end
					if (!hit)
						res.status = ST_NOTFOUND;
				end
				default: begin
					if (pos < length)
						res.read_value = entries[pos];
					else
						res.status = ST_RANGE;
				end
			endcase
			res.list_length = length[LEN_W-1:0];
			pending_results.push_back(res);
		endfunction

		function void check_result(sle_res_t got);
			sle_res_t want;
			string bad;
			if (pending_results.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d length %0d",
						got.status, got.list_length);
				return;
			end
			want = pending_results.pop_front();
			bad = "";
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.found_index !== want.found_index) bad = {bad, " found_index"};
			if (got.read_value !== want.read_value) bad = {bad, " read_value"};
			if (got.removed_count !== want.removed_count) bad = {bad, " removed_count"};
			if (got.list_length !== want.list_length) bad = {bad, " list_length"};
			if (bad != "") begin
				errors++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch in%s: expected st %0d idx %0d rd %0d rm %0d len %0d",
						bad, want.status, want.found_index, want.read_value,
						want.removed_count, want.list_length);
					$display("  got st %0d idx %0d rd %0d rm %0d len %0d",
						got.status, got.found_index, got.read_value,
						got.removed_count, got.list_length);
				end
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	sle_req_t request;
	logic     busy;
	logic     done;
	sle_res_t result;

	list_shadow shadow;
	logic signed [31:0] value_pool [8];
	// A result cannot be held off, so receiver stalls leave only the sender's idling.
	int unsigned idle_pct [4] = '{0, 65, 0, 21};

	sequential_list_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			shadow.check_result(result);
	end

	function automatic sle_req_t make_req(logic [1:0] op, int unsigned pos,
		logic [31:0] val);
		sle_req_t r;
		r.operation = op;
		r.position = pos[LEN_W-1:0];
		r.value = val;
		return r;
	endfunction

	// Mostly a few pool values, so that duplicates and hits are common.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2, 3: return value_pool[$urandom_range(0, 7)];
			default: return value_pool[$urandom_range(0, 2)];
		endcase
	endfunction

	function automatic sle_req_t pick_request();
		int unsigned len;
		int unsigned ins_weight;
		int unsigned pos;
		logic [1:0] op;
		len = shadow.length;
		ins_weight = (len < 4) ? 70 : (len >= CAPACITY - 1) ? 25 : 45;
		if ($urandom_range(0, 99) < ins_weight) begin
			op = OP_INSERT;
		end else begin
			case ($urandom_range(0, 2))
				0: op = OP_DELETE;
				1: op = OP_FIND;
				default: op = OP_READ;
			endcase
		end
		if ($urandom_range(0, 99) < 15 || (op == OP_READ && len == 0))
			pos = $urandom_range(0, 2**LEN_W - 1);
		else if (op == OP_INSERT)
			pos = $urandom_range(0, len);
		else
			pos = $urandom_range(0, len - 1);
		return make_req(op, pos, pick_value());
	endfunction

	// Presents one word and returns at the edge where it is taken; start stays high.
	task automatic send_word(sle_req_t req, int unsigned idle);
		if ($urandom_range(0, 99) < idle) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.note_request(req);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (shadow.pending_results.size() != 0);
	endtask

	// Empties the list, fills it with one value and removes the whole list at once.
	task automatic refill_uniform(int unsigned idle);
		logic [31:0] v;
		while (shadow.length != 0)
			send_word(make_req(OP_DELETE, $urandom_range(0, 2**LEN_W - 1),
				shadow.entries[0]), idle);
		v = pick_value();
		repeat (CAPACITY)
			send_word(make_req(OP_INSERT, $urandom_range(0, shadow.length), v), idle);
		send_word(make_req(OP_FIND, 0, v), idle);
		send_word(make_req(OP_DELETE, 0, v), idle);
	endtask

	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int ph;
		int n;
		shadow = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every lookup misses, an insert past the end is refused.
		send_word(make_req(OP_READ, 0, 0), 0);
		send_word(make_req(OP_DELETE, 0, 5), 0);
		send_word(make_req(OP_FIND, 0, 5), 0);
		send_word(make_req(OP_INSERT, 1, 9), 0);
		send_word(make_req(OP_INSERT, 0, 32'h8000_0000), 0);
		send_word(make_req(OP_INSERT, 1, 32'h7fff_ffff), 0);
		send_word(make_req(OP_INSERT, 1, 0), 0);
		send_word(make_req(OP_FIND, 0, 32'h7fff_ffff), 0);
		send_word(make_req(OP_READ, 2, 0), 0);
		send_word(make_req(OP_READ, 31, 32'hffff_ffff), 0);
		send_word(make_req(OP_DELETE, 31, 0), 0);
		// Fill to capacity at the head so the maximum ends at the last index.
		repeat (CAPACITY - 2)
			send_word(make_req(OP_INSERT, 0, 7), 0);
		send_word(make_req(OP_FIND, 0, 32'h7fff_ffff), 0);
		// A full list wins over a bad position.
		send_word(make_req(OP_INSERT, 31, 3), 0);
		send_word(make_req(OP_READ, CAPACITY - 1, 0), 0);
		send_word(make_req(OP_DELETE, 0, 7), 0);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < 8; n++)
				value_pool[n] = $urandom;
			value_pool[3] = 32'h0000_0000;
			value_pool[4] = 32'hffff_ffff;
			value_pool[5] = 32'h8000_0000;
			value_pool[6] = 32'h7fff_ffff;
			refill_uniform(idle_pct[ph]);
			for (n = 0; n < 280; n++) begin
				send_word(pick_request(), idle_pct[ph]);
				if (n == 140)
					drain();
			end
			drain();
		end

		start <= 1'b0;
		while (shadow.pending_results.size() != 0) @(posedge clk);
		repeat (CAPACITY + 10) @(posedge clk);
		shadow.errors += shadow.pending_results.size();
		if (shadow.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
